// File: sv/lwps_pkg.sv
// Shared types and constants for the window pixel write sequencer.
`timescale 1ns / 1ps
package lwps_pkg;

  // Input action codes
  localparam logic [1:0] ACT_OPEN  = 2'd0;
  localparam logic [1:0] ACT_PIXEL = 2'd1;
  localparam logic [1:0] ACT_FILL  = 2'd2;

  // Result status codes
  localparam logic [1:0] STATUS_OK     = 2'd0;
  localparam logic [1:0] STATUS_REJECT = 2'd1;
  localparam logic [1:0] STATUS_EMPTY  = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_PANEL_WIDTH   = 2'd0;
  localparam logic [1:0] CFG_PANEL_HEIGHT  = 2'd1;
  localparam logic [1:0] CFG_COLUMN_OFFSET = 2'd2;
  localparam logic [1:0] CFG_ROW_OFFSET    = 2'd3;

  localparam logic [8:0]  PANEL_SIZE_RESET = 9'd240;
  localparam logic [16:0] LEFT_MAX         = 17'h1FFFF;
  localparam logic [7:0]  BYTE_MASK        = 8'hff;

  // Classified job handed from front to back
  typedef enum logic [1:0] {
    KIND_OPEN,
    KIND_PIXEL,
    KIND_REJECT,
    KIND_EMPTY
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] col_first;
    logic [15:0] col_last;
    logic [15:0] row_first;
    logic [15:0] row_last;
    logic [15:0] color;
    logic        done;
  } job_t;

endpackage

// File: sv/lwps_front.sv
// Front end: config registers, region check, pixel bookkeeping, job build.
`timescale 1ns / 1ps
module lwps_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [8:0]        cfg_data,
  input  logic              accept,
  input  logic [1:0]        action,
  input  logic [15:0]       col_first,
  input  logic [15:0]       row_first,
  input  logic [15:0]       col_last,
  input  logic [15:0]       row_last,
  input  logic [15:0]       pixel_color,
  output logic              push,
  output lwps_pkg::job_t    job
);

  logic [8:0]  panel_width_r, panel_height_r;
  logic [7:0]  column_offset_r, row_offset_r;
  logic [16:0] pixels_left_r, pixels_left_nxt;
  logic [15:0] fill_color_r, fill_color_nxt;

  logic        reject;
  logic [8:0]  col_span, row_span;
  logic [17:0] area;
  logic [16:0] area_sat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      panel_width_r   <= lwps_pkg::PANEL_SIZE_RESET;
      panel_height_r  <= lwps_pkg::PANEL_SIZE_RESET;
      column_offset_r <= '0;
      row_offset_r    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lwps_pkg::CFG_PANEL_WIDTH:   panel_width_r   <= cfg_data;
        lwps_pkg::CFG_PANEL_HEIGHT:  panel_height_r  <= cfg_data;
        lwps_pkg::CFG_COLUMN_OFFSET: column_offset_r <= cfg_data[7:0];
        lwps_pkg::CFG_ROW_OFFSET:    row_offset_r    <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // A valid region has last below panel size, so spans fit in 9 bits
  assign reject = (col_last < col_first) || (row_last < row_first) ||
                  (col_last >= {7'd0, panel_width_r}) ||
                  (row_last >= {7'd0, panel_height_r});
  assign col_span = col_last[8:0] - col_first[8:0] + 9'd1;
  assign row_span = row_last[8:0] - row_first[8:0] + 9'd1;
  assign area     = {9'd0, col_span} * {9'd0, row_span};
  assign area_sat = area[17] ? lwps_pkg::LEFT_MAX : area[16:0];

  always_comb begin
    pixels_left_nxt = pixels_left_r;
    fill_color_nxt  = fill_color_r;
    push            = 1'b0;
    job.kind        = lwps_pkg::KIND_REJECT;
    job.col_first   = {8'd0, column_offset_r} + col_first;
    job.col_last    = {8'd0, column_offset_r} + col_last;
    job.row_first   = {8'd0, row_offset_r} + row_first;
    job.row_last    = {8'd0, row_offset_r} + row_last;
    job.color       = (action == lwps_pkg::ACT_PIXEL) ? pixel_color : fill_color_r;
    job.done        = (pixels_left_r == 17'd1);
    if (accept) begin
      unique case (action)
        lwps_pkg::ACT_OPEN: begin
          push = 1'b1;
          if (!reject) begin
            job.kind        = lwps_pkg::KIND_OPEN;
            pixels_left_nxt = area_sat;
            fill_color_nxt  = pixel_color;
          end
        end
        lwps_pkg::ACT_PIXEL, lwps_pkg::ACT_FILL: begin
          push = 1'b1;
          if (pixels_left_r == '0) begin
            job.kind = lwps_pkg::KIND_EMPTY;
          end else begin
            job.kind        = lwps_pkg::KIND_PIXEL;
            pixels_left_nxt = pixels_left_r - 17'd1;
          end
        end
        default: ;  // unused action: dropped
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pixels_left_r <= '0;
      fill_color_r  <= '0;
    end else begin
      pixels_left_r <= pixels_left_nxt;
      fill_color_r  <= fill_color_nxt;
    end
  end

endmodule

// File: sv/lwps_queue.sv
// Two-entry job queue between front and back.
`timescale 1ns / 1ps
module lwps_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  lwps_pkg::job_t push_job,
  input  logic           pop,
  output logic           full,
  output logic           not_empty,
  output lwps_pkg::job_t head
);

  lwps_pkg::job_t entry_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;

  assign full      = (count_r == 2'd2);
  assign not_empty = (count_r != 2'd0);
  assign head      = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      count_r <= count_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// File: sv/lwps_back.sv
// Back end: expands queued jobs into display words, one per cycle unless out_ready stalls the output.
`timescale 1ns / 1ps
module lwps_back #(
  parameter logic [7:0] COLUMN_SET_CODE   = 8'd42,
  parameter logic [7:0] ROW_SET_CODE      = 8'd43,
  parameter logic [7:0] MEMORY_WRITE_CODE = 8'd44
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           job_valid,
  input  lwps_pkg::job_t job,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [7:0]     out_byte,
  output logic           out_is_command,
  output logic           out_run_end,
  output logic           out_window_done,
  output logic [1:0]     out_status
);

  // Word slots of the open-window sequence
  localparam logic [3:0] SLOT_COL_CMD = 4'd0;
  localparam logic [3:0] SLOT_C0_HI   = 4'd1;
  localparam logic [3:0] SLOT_C0_LO   = 4'd2;
  localparam logic [3:0] SLOT_C1_HI   = 4'd3;
  localparam logic [3:0] SLOT_C1_LO   = 4'd4;
  localparam logic [3:0] SLOT_ROW_CMD = 4'd5;
  localparam logic [3:0] SLOT_R0_HI   = 4'd6;
  localparam logic [3:0] SLOT_R0_LO   = 4'd7;
  localparam logic [3:0] SLOT_R1_HI   = 4'd8;
  localparam logic [3:0] SLOT_R1_LO   = 4'd9;
  localparam logic [3:0] SLOT_MEM_CMD = 4'd10;

  logic [3:0] step_r, step_nxt;
  logic       valid_r, valid_nxt;
  logic [7:0] byte_r, byte_nxt;
  logic       cmd_r, cmd_nxt, last_r, last_nxt, done_r, done_nxt;
  logic [1:0] status_r, status_nxt;
  logic       emit;

  assign emit = job_valid && (!valid_r || out_ready);

  always_comb begin
    byte_nxt   = '0;
    cmd_nxt    = 1'b0;
    last_nxt   = 1'b1;
    done_nxt   = 1'b0;
    status_nxt = lwps_pkg::STATUS_OK;
    unique case (job.kind)
      lwps_pkg::KIND_OPEN: begin
        last_nxt = (step_r == SLOT_MEM_CMD);
        unique case (step_r)
          SLOT_COL_CMD: begin byte_nxt = COLUMN_SET_CODE;   cmd_nxt = 1'b1; end
          SLOT_C0_HI:   byte_nxt = job.col_first[15:8];
          SLOT_C0_LO:   byte_nxt = job.col_first[7:0] & lwps_pkg::BYTE_MASK;
          SLOT_C1_HI:   byte_nxt = job.col_last[15:8];
          SLOT_C1_LO:   byte_nxt = job.col_last[7:0];
          SLOT_ROW_CMD: begin byte_nxt = ROW_SET_CODE;      cmd_nxt = 1'b1; end
          SLOT_R0_HI:   byte_nxt = job.row_first[15:8];
          SLOT_R0_LO:   byte_nxt = job.row_first[7:0];
          SLOT_R1_HI:   byte_nxt = job.row_last[15:8];
          SLOT_R1_LO:   byte_nxt = job.row_last[7:0];
          SLOT_MEM_CMD: begin byte_nxt = MEMORY_WRITE_CODE; cmd_nxt = 1'b1; end
          default: ;
        endcase
      end
      lwps_pkg::KIND_PIXEL: begin
        byte_nxt = (step_r == SLOT_COL_CMD) ? job.color[15:8] : job.color[7:0];
        last_nxt = (step_r != SLOT_COL_CMD);
        done_nxt = job.done;
      end
      lwps_pkg::KIND_REJECT: status_nxt = lwps_pkg::STATUS_REJECT;
      lwps_pkg::KIND_EMPTY:  status_nxt = lwps_pkg::STATUS_EMPTY;
      default: ;
    endcase
  end

  assign pop      = emit && last_nxt;
  assign step_nxt = pop ? SLOT_COL_CMD : step_r + 4'd1;

  always_comb begin
    if (emit)           valid_nxt = 1'b1;
    else if (out_ready) valid_nxt = 1'b0;
    else                valid_nxt = valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      step_r  <= SLOT_COL_CMD;
    end else begin
      valid_r <= valid_nxt;
      if (emit) step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      byte_r   <= byte_nxt;
      cmd_r    <= cmd_nxt;
      last_r   <= last_nxt;
      done_r   <= done_nxt;
      status_r <= status_nxt;
    end
  end

  assign out_valid       = valid_r;
  assign out_byte        = byte_r;
  assign out_is_command  = cmd_r;
  assign out_run_end     = last_r;
  assign out_window_done = done_r;
  assign out_status      = status_r;

endmodule

// File: sv/lcd_window_pixel_write_sequencer.sv
// Top level of the window pixel write sequencer.
`timescale 1ns / 1ps
// The first word of an item reaches out_* through the queue entry, then the output register.
// Throughput: back end, one word per cycle unless out_ready stalls; pixel 2 words, open window 11,
// rejected region or empty pixel 1; front accepts every cycle while the 2-deep queue has room.
// Reset (rst_n low, synchronous): panel 240x240, offsets 0, pixels left 0, fill color 0,
// queue emptied, no word pending on the output.
module lcd_window_pixel_write_sequencer #(
  parameter logic [7:0] COLUMN_SET_CODE   = 8'd42,
  parameter logic [7:0] ROW_SET_CODE      = 8'd43,
  parameter logic [7:0] MEMORY_WRITE_CODE = 8'd44
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration write port
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [8:0]  cfg_data,
  // request channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_action,
  input  logic [15:0] in_col_first,
  input  logic [15:0] in_row_first,
  input  logic [15:0] in_col_last,
  input  logic [15:0] in_row_last,
  input  logic [15:0] in_pixel_color,
  // word channel toward the display link
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        out_is_command,
  output logic        out_run_end,
  output logic        out_window_done,
  output logic [1:0]  out_status
);

  logic           accept;
  logic           push, pop, full, not_empty;
  lwps_pkg::job_t push_job, head_job;

  // Front owns pixels_left, so each job leaves it fully resolved; the
  // back only sequences bytes and never looks back at the front.
  assign in_ready = !full;
  assign accept   = in_valid && in_ready;

  lwps_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .accept      (accept),
    .action      (in_action),
    .col_first   (in_col_first),
    .row_first   (in_row_first),
    .col_last    (in_col_last),
    .row_last    (in_row_last),
    .pixel_color (in_pixel_color),
    .push        (push),
    .job         (push_job)
  );

  lwps_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_job  (push_job),
    .pop       (pop),
    .full      (full),
    .not_empty (not_empty),
    .head      (head_job)
  );

  // Back pops the head job on its final word; output register parts the
  // display side from the queue.
  lwps_back #(
    .COLUMN_SET_CODE   (COLUMN_SET_CODE),
    .ROW_SET_CODE      (ROW_SET_CODE),
    .MEMORY_WRITE_CODE (MEMORY_WRITE_CODE)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .job_valid       (not_empty),
    .job             (head_job),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .out_is_command  (out_is_command),
    .out_run_end     (out_run_end),
    .out_window_done (out_window_done),
    .out_status      (out_status)
  );

endmodule
